[rtl/swamm_pkg.sv]
// shared constants for the sliding window mean / min / max block
// no dependencies; used by swamm_div and sliding_window_avg_min_max
`timescale 1ns / 1ps
`default_nettype none

package swamm_pkg;

	// sample field width and full-scale value
	localparam int SAMPLE_W = 12;
	localparam int SAMPLE_MAX = 4095;

	// default number of slots in the window
	localparam int WINDOW_DEF = 500;

endpackage

`default_nettype wire

[rtl/swamm_div.sv]
// reciprocal multiply that divides the window total by the fixed window length
// quotient registered after the product register that start loads; depends on swamm_pkg
`timescale 1ns / 1ps
`default_nettype none

module swamm_div #(
	parameter int DIVISOR = swamm_pkg::WINDOW_DEF,
	parameter int TOTAL_W = 21
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [TOTAL_W-1:0]            dividend,
	output logic                               busy,
	output logic [swamm_pkg::SAMPLE_W-1:0]     quotient
);

	localparam int QW = swamm_pkg::SAMPLE_W;
	// shift wide enough that the floor is exact for every total below 2**TOTAL_W
	localparam int SHIFT = TOTAL_W + $clog2(DIVISOR);
	localparam int RECIP_W = TOTAL_W + 2;
	localparam int PROD_W = TOTAL_W + RECIP_W;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	logic [PROD_W-1:0] prod_s1;
	logic [QW-1:0]     quo_q;
	logic              busy_q;

	// multiply by the rounded-up reciprocal, then keep the integer part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			prod_s1 <= '0;
			quo_q   <= '0;
		end else begin
			busy_q <= start;
			if (start) begin
				prod_s1 <= {{RECIP_W{1'b0}}, dividend} * {{TOTAL_W{1'b0}}, RECIP};
			end
			if (busy_q) begin
				quo_q <= prod_s1[SHIFT +: QW];
			end
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

[rtl/sliding_window_avg_min_max.sv]
// Sliding window mean, minimum and maximum of 12-bit ADC samples. Each accepted
// sample overwrites the oldest of WINDOW slots held in a block memory and gives one
// result beat with the floor mean, minimum and maximum of all slots (slots never
// written count as zero). After reset the block runs a clearing pass, one slot per
// cycle, with in_ready low. Each sample then passes through these steps: read the
// old slot, update the running total and write the new sample, scan every slot
// through the single memory read port, then finish the scan, settle the mean and
// load the output register (later while an earlier result beat still waits there
// unaccepted); the mean comes from a reciprocal multiply started at the top of the
// scan. One item is worked at a time; a finished result waits in the output
// register while the next sample is taken. Depends on swamm_pkg and swamm_div.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_avg_min_max #(
	parameter int WINDOW = swamm_pkg::WINDOW_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [swamm_pkg::SAMPLE_W-1:0] sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [swamm_pkg::SAMPLE_W-1:0]     window_mean,
	output logic [swamm_pkg::SAMPLE_W-1:0]     window_min,
	output logic [swamm_pkg::SAMPLE_W-1:0]     window_max
);

	localparam int SW = swamm_pkg::SAMPLE_W;
	localparam int IDX_W = $clog2(WINDOW);
	localparam int TOTAL_W = $clog2(WINDOW * swamm_pkg::SAMPLE_MAX + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
	localparam logic [SW-1:0] FULL_SCALE = SW'(swamm_pkg::SAMPLE_MAX);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(WINDOW * swamm_pkg::SAMPLE_MAX);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DIVIDE,
		ST_DELIVER
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   slot_q;
	logic [SW-1:0]      sample_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SW-1:0]      min_q;
	logic [SW-1:0]      max_q;
	logic               scan_vld_s1;
	logic [SW-1:0]      rd_data_s1;
	logic               out_valid_q;
	logic [SW-1:0]      mean_q;
	logic [SW-1:0]      omin_q;
	logic [SW-1:0]      omax_q;

	logic [SW-1:0]      ring [WINDOW];

	logic               accept;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [SW-1:0]      wr_data;
	logic               div_start;
	logic               div_busy;
	logic [SW-1:0]      div_quo;
	logic               load_out;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	// memory port selection
	assign rd_en   = accept || (state_q == ST_SCAN);
	assign rd_addr = (state_q == ST_SCAN) ? cnt_q : slot_q;
	assign wr_en   = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
	assign wr_addr = (state_q == ST_CLEAR) ? cnt_q : slot_q;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : sample_q;

	// sample ring, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= ring[rd_addr];
		end
	end

	// divider starts on the first scan cycle, after the total is updated
	assign div_start = (state_q == ST_SCAN) && (cnt_q == '0);

	swamm_div #(
		.DIVISOR (WINDOW),
		.TOTAL_W (TOTAL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign load_out = (state_q == ST_DELIVER) && (!out_valid_q || out_ready);

	// sequencer, running total and min / max scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			slot_q      <= '0;
			sample_q    <= '0;
			total_q     <= '0;
			min_q       <= '0;
			max_q       <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (scan_vld_s1) begin
				if (rd_data_s1 < min_q) begin
					min_q <= rd_data_s1;
				end
				if (rd_data_s1 > max_q) begin
					max_q <= rd_data_s1;
				end
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						sample_q <= sample;
						state_q  <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					total_q <= total_q - TOTAL_W'(rd_data_s1) + TOTAL_W'(sample_q);
					slot_q  <= (slot_q == IDX_LAST) ? '0 : slot_q + 1'b1;
					min_q   <= FULL_SCALE;
					max_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN_LAST;
					end
				end
				ST_SCAN_LAST: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (!div_busy) begin
						state_q <= ST_DELIVER;
					end
				end
				ST_DELIVER: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register, frees the input side while a result beat waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mean_q <= div_quo;
			omin_q <= min_q;
			omax_q <= max_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign window_mean = mean_q;
	assign window_min  = omin_q;
	assign window_max  = omax_q;

`ifndef ASSERT_OFF
	// running total never exceeds a window of full-scale samples
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOTAL_MAX)
		else $error("running total out of range");

	// a mean always lies between the window minimum and maximum
	a_mean_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (div_quo >= min_q) && (div_quo <= max_q))
		else $error("mean outside min/max");

	// an accepted sample goes straight to the total update
	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_UPDATE))
		else $error("accepted sample not updated");

	// divider finished whenever a result is loaded
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !div_busy)
		else $error("result loaded while divider busy");
`endif

endmodule

`default_nettype wire
